// ----- hw/rtl/cr1u_pkg.sv -----
// Types, constants and rounding helpers shared by the complex rank-one update block.
package cr1u_pkg;

	localparam int DATA_W    = 16;
	localparam int FRAC_W    = DATA_W - 2;
	localparam int ROW_W     = 6;
	localparam int OP_W      = DATA_W + 1;   // room for a conjugated most-negative value
	localparam int PROD_W    = 2 * OP_W;
	localparam int SUM_W     = PROD_W + 1;
	localparam int CFG_IDX_W = 3;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic signed [OP_W-1:0]   op_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0]  sum_t;

	typedef enum logic {
		CMD_LOAD   = 1'b0,
		CMD_UPDATE = 1'b1
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ALPHA_RE   = 3'd0,
		REG_ALPHA_IM   = 3'd1,
		REG_CONJ_X     = 3'd2,
		REG_CONJ_Y     = 3'd3,
		REG_ACCUMULATE = 3'd4
	} reg_idx_t;

	localparam data_t ALPHA_RE_RESET = DATA_W'(16384);
	localparam data_t ALPHA_IM_RESET = DATA_W'(0);

	localparam sum_t DATA_MAX = SUM_W'((2 ** (DATA_W - 1)) - 1);
	localparam sum_t DATA_MIN = ~DATA_MAX;
	localparam sum_t HALF_LSB = SUM_W'(2 ** (FRAC_W - 1));

	typedef struct packed {
		data_t re;
		data_t im;
	} cval_t;

	typedef struct packed {
		cmd_t             cmd;
		logic [ROW_W-1:0] row;
		data_t            x_re;
		data_t            x_im;
		data_t            y_re;
		data_t            y_im;
		data_t            a_re;
		data_t            a_im;
		logic             last_in;
	} in_word_t;

	typedef struct packed {
		data_t            new_re;
		data_t            new_im;
		logic [ROW_W-1:0] out_row;
		logic             last_out;
	} out_word_t;

	typedef struct packed {
		data_t alpha_re;
		data_t alpha_im;
		logic  conj_x;
		logic  conj_y;
		logic  accumulate;
	} cfg_t;

	function automatic data_t sat_data(input sum_t v);
		data_t r;
		if (v > DATA_MAX) begin
			r = DATA_MAX[DATA_W-1:0];
		end else if (v < DATA_MIN) begin
			r = DATA_MIN[DATA_W-1:0];
		end else begin
			r = v[DATA_W-1:0];
		end
		return r;
	endfunction

	// (p +/- q) rounded half up to FRAC_W fraction bits, then saturated
	function automatic data_t round_pair(input prod_t p, input prod_t q, input logic neg_q);
		sum_t acc;
		sum_t shf;
		acc = SUM_W'(p) + (neg_q ? -SUM_W'(q) : SUM_W'(q)) + HALF_LSB;
		shf = acc >>> FRAC_W;
		return sat_data(shf);
	endfunction

endpackage

// ----- hw/rtl/cr1u_cfg.sv -----
// Configuration registers of the complex rank-one update block.
module cr1u_cfg
	import cr1u_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alpha_re   <= ALPHA_RE_RESET;
			cfg_q.alpha_im   <= ALPHA_IM_RESET;
			cfg_q.conj_x     <= 1'b0;
			cfg_q.conj_y     <= 1'b0;
			cfg_q.accumulate <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ALPHA_RE:   cfg_q.alpha_re   <= cfg_data;
				REG_ALPHA_IM:   cfg_q.alpha_im   <= cfg_data;
				REG_CONJ_X:     cfg_q.conj_x     <= cfg_data[0];
				REG_CONJ_Y:     cfg_q.conj_y     <= cfg_data[0];
				REG_ACCUMULATE: cfg_q.accumulate <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hw/rtl/cr1u_xmem.sv -----
// Storage for the x vector: one write port, one registered read port.
module cr1u_xmem
	import cr1u_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  cval_t         wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output cval_t         rd_data
);

	cval_t mem [DEPTH];
	cval_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- hw/rtl/cr1u_cmul.sv -----
// Two-stage complex multiplier: registered partial products, then rounded and saturated sums.
module cr1u_cmul
	import cr1u_pkg::*;
(
	input  logic  clk,
	input  logic  en_s1,
	input  logic  en_s2,
	input  op_t   a_re,
	input  op_t   a_im,
	input  op_t   b_re,
	input  op_t   b_im,
	output data_t r_re,
	output data_t r_im
);

	prod_t rr_s1, ii_s1, ri_s1, ir_s1;
	data_t re_s2, im_s2;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			rr_s1 <= PROD_W'(a_re) * PROD_W'(b_re);
			ii_s1 <= PROD_W'(a_im) * PROD_W'(b_im);
			ri_s1 <= PROD_W'(a_re) * PROD_W'(b_im);
			ir_s1 <= PROD_W'(a_im) * PROD_W'(b_re);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			re_s2 <= round_pair(rr_s1, ii_s1, 1'b1);
			im_s2 <= round_pair(ri_s1, ir_s1, 1'b0);
		end
	end

	assign r_re = re_s2;
	assign r_im = im_s2;

endmodule

// ----- hw/rtl/complex_rank1_update.sv -----
// Complex rank-one update A = alpha*x*y^T (+ A when accumulate is set), Q2.14 components.
// Load words (cmd 0) write one x element into an on-chip store indexed by row; update
// words (cmd 1) carry one matrix element, its row and the column's y element, and
// produce one result word. One word is accepted per cycle while item_stall is low. An
// update passes the x store read, alpha*x products and rounding, (alpha*x)*y products
// and rounding, and the final add. Each stage holds while the stage after it is full
// and stalled, so bubbles are squeezed out before the input stalls. Loads write the store
// at acceptance and updates read it at acceptance, so a load is seen by every later update.
// Configuration writes are taken every cycle and must only occur while the block is idle.
module complex_rank1_update
	import cr1u_pkg::*;
#(
	parameter int ROWS_MAX = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  in_word_t             item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output out_word_t            result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data
);

	localparam int AW = (ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 1;
	localparam int XW = (AW > ROW_W) ? AW : ROW_W;

	cfg_t cfg;

	logic          accept;
	logic          in_range;
	logic [XW-1:0] row_x;
	logic [AW-1:0] addr;
	cval_t         x_rd;

	logic v1_q, v2_q, v3_q, v4_q, v5_q, result_valid_q;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy_out;

	logic             in_range_s1;
	data_t            y_re_s1, y_im_s1, a_re_s1, a_im_s1;
	data_t            y_re_s2, y_im_s2, a_re_s2, a_im_s2;
	data_t            y_re_s3, y_im_s3, a_re_s3, a_im_s3;
	data_t            a_re_s4, a_im_s4, a_re_s5, a_im_s5;
	logic [ROW_W-1:0] row_s1, row_s2, row_s3, row_s4, row_s5;
	logic             last_s1, last_s2, last_s3, last_s4, last_s5;

	op_t   xp_re, xp_im, yp_re, yp_im;
	data_t s_re, s_im, p_re, p_im;
	data_t n_re, n_im;
	out_word_t result_q;

	cr1u_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign cfg_ready = 1'b1;

	// stage handshake: a stage loads when it is empty or its contents move on
	assign rdy_out    = !result_valid_q || !result_stall;
	assign rdy5       = !v5_q || rdy_out;
	assign rdy4       = !v4_q || rdy5;
	assign rdy3       = !v3_q || rdy4;
	assign rdy2       = !v2_q || rdy3;
	assign rdy1       = !v1_q || rdy2;
	assign item_stall = !rdy1;
	assign accept     = item_valid && rdy1;

	assign row_x    = XW'(item.row);
	assign addr     = row_x[AW-1:0];
	assign in_range = 32'(item.row) < ROWS_MAX;

	cr1u_xmem #(
		.DEPTH (ROWS_MAX),
		.AW    (AW)
	) u_xmem (
		.clk     (clk),
		.wr_en   (accept && item.cmd == CMD_LOAD && in_range),
		.wr_addr (addr),
		.wr_data (cval_t'{re: item.x_re, im: item.x_im}),
		.rd_en   (accept && item.cmd == CMD_UPDATE),
		.rd_addr (addr),
		.rd_data (x_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q           <= 1'b0;
			v2_q           <= 1'b0;
			v3_q           <= 1'b0;
			v4_q           <= 1'b0;
			v5_q           <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (rdy1) begin
				v1_q <= item_valid && item.cmd == CMD_UPDATE;
			end
			if (rdy2) begin
				v2_q <= v1_q;
			end
			if (rdy3) begin
				v3_q <= v2_q;
			end
			if (rdy4) begin
				v4_q <= v3_q;
			end
			if (rdy5) begin
				v5_q <= v4_q;
			end
			if (rdy_out) begin
				result_valid_q <= v5_q;
			end
		end
	end

	// side payload follows its stage
	always_ff @(posedge clk) begin
		if (rdy1) begin
			in_range_s1 <= in_range;
			y_re_s1     <= item.y_re;
			y_im_s1     <= item.y_im;
			a_re_s1     <= item.a_re;
			a_im_s1     <= item.a_im;
			row_s1      <= item.row;
			last_s1     <= item.last_in;
		end
		if (rdy2) begin
			y_re_s2 <= y_re_s1;
			y_im_s2 <= y_im_s1;
			a_re_s2 <= a_re_s1;
			a_im_s2 <= a_im_s1;
			row_s2  <= row_s1;
			last_s2 <= last_s1;
		end
		if (rdy3) begin
			y_re_s3 <= y_re_s2;
			y_im_s3 <= y_im_s2;
			a_re_s3 <= a_re_s2;
			a_im_s3 <= a_im_s2;
			row_s3  <= row_s2;
			last_s3 <= last_s2;
		end
		if (rdy4) begin
			a_re_s4 <= a_re_s3;
			a_im_s4 <= a_im_s3;
			row_s4  <= row_s3;
			last_s4 <= last_s3;
		end
		if (rdy5) begin
			a_re_s5 <= a_re_s4;
			a_im_s5 <= a_im_s4;
			row_s5  <= row_s4;
			last_s5 <= last_s4;
		end
	end

	// x' from the store (zero beyond the store), y' from the word; conjugation may
	// reach +2^15, hence the extra operand bit
	always_comb begin
		xp_re = in_range_s1 ? OP_W'(x_rd.re) : '0;
		xp_im = in_range_s1 ? OP_W'(x_rd.im) : '0;
		if (cfg.conj_x) begin
			xp_im = -xp_im;
		end
		yp_re = OP_W'(y_re_s3);
		yp_im = cfg.conj_y ? -OP_W'(y_im_s3) : OP_W'(y_im_s3);
	end

	cr1u_cmul u_mul_ax (
		.clk   (clk),
		.en_s1 (rdy2),
		.en_s2 (rdy3),
		.a_re  (OP_W'(cfg.alpha_re)),
		.a_im  (OP_W'(cfg.alpha_im)),
		.b_re  (xp_re),
		.b_im  (xp_im),
		.r_re  (s_re),
		.r_im  (s_im)
	);

	cr1u_cmul u_mul_sy (
		.clk   (clk),
		.en_s1 (rdy4),
		.en_s2 (rdy5),
		.a_re  (OP_W'(s_re)),
		.a_im  (OP_W'(s_im)),
		.b_re  (yp_re),
		.b_im  (yp_im),
		.r_re  (p_re),
		.r_im  (p_im)
	);

	always_comb begin
		if (cfg.accumulate) begin
			n_re = sat_data(SUM_W'(a_re_s5) + SUM_W'(p_re));
			n_im = sat_data(SUM_W'(a_im_s5) + SUM_W'(p_im));
		end else begin
			n_re = p_re;
			n_im = p_im;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out) begin
			result_q.new_re   <= n_re;
			result_q.new_im   <= n_im;
			result_q.out_row  <= row_s5;
			result_q.last_out <= last_s5;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for complex_rank1_update: a directed table, then random words under several settings.
module testbench
	import cr1u_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ROWS           = 2 ** ROW_W;
	localparam int REG_COUNT      = int'(REG_ACCUMULATE) + 1;
	localparam int PHASES         = 8;
	localparam int PHASE_WORDS    = 135;
	localparam int PRESSURE_PHASE = 4;
	localparam int DRAIN_CYCLES   = 12;
	localparam int RX_HOLD_CYCLES = 400;
	localparam int WATCHDOG_LIMIT = 4000;

	localparam data_t D_MAX = data_t'(32767);
	localparam data_t D_MIN = data_t'(-32768);
	localparam data_t ONE_Q = data_t'(16384);

	typedef struct {
		in_word_t  w;
		bit        pinned;
		out_word_t res;
	} dir_row_t;

	logic      clk          = 1'b0;
	logic      arst_n       = 1'b0;
	logic      item_valid   = 1'b0;
	logic      item_stall;
	in_word_t  item         = '0;
	logic      result_valid;
	logic      result_stall = 1'b0;
	out_word_t result;
	logic      cfg_valid    = 1'b0;
	logic      cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DATA_W-1:0]    cfg_data  = '0;

	// predictor state
	cfg_t  model_cfg;
	data_t x_mem_re [ROWS];
	data_t x_mem_im [ROWS];

	out_word_t pending_elems[$];
	dir_row_t  directed_tab[$];
	logic [ROW_W-1:0] loaded_rows[$];
	bit        row_loaded [ROWS];

	int fail_count  = 0;
	int quiet_cycles = 0;
	bit burst_mode  = 1'b0;
	logic rx_hold_req = 1'b0;
	bit hold_active = 1'b0;
	bit hold_done   = 1'b0;

	complex_rank1_update dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #1 clk = ~clk;

	function automatic longint fit_data(input longint v);
		if (v > longint'(D_MAX)) begin
			return longint'(D_MAX);
		end
		if (v < longint'(D_MIN)) begin
			return longint'(D_MIN);
		end
		return v;
	endfunction

	// exact sum, half-up rounding to FRAC_W fraction bits, then saturation
	function automatic longint round_frac(input longint p, input longint q);
		longint half;
		half = longint'(1) <<< (FRAC_W - 1);
		return fit_data((p + q + half) >>> FRAC_W);
	endfunction

	function automatic out_word_t update_element(input in_word_t w);
		longint ar, ai, xr, xi, yr, yi, sr, si, pr, pim, nr, ni;
		data_t tmp;
		out_word_t o;
		ar = longint'(model_cfg.alpha_re);
		ai = longint'(model_cfg.alpha_im);
		xr = longint'(x_mem_re[w.row]);
		xi = longint'(x_mem_im[w.row]);
		if (model_cfg.conj_x) begin
			xi = -xi;
		end
		tmp = w.y_re;
		yr = longint'(tmp);
		tmp = w.y_im;
		yi = longint'(tmp);
		if (model_cfg.conj_y) begin
			yi = -yi;
		end
		sr = round_frac(ar * xr, -(ai * xi));
		si = round_frac(ar * xi, ai * xr);
		pr = round_frac(sr * yr, -(si * yi));
		pim = round_frac(sr * yi, si * yr);
		if (model_cfg.accumulate) begin
			tmp = w.a_re;
			nr = fit_data(longint'(tmp) + pr);
			tmp = w.a_im;
			ni = fit_data(longint'(tmp) + pim);
		end else begin
			nr = pr;
			ni = pim;
		end
		o.new_re   = data_t'(nr);
		o.new_im   = data_t'(ni);
		o.out_row  = w.row;
		o.last_out = w.last_in;
		return o;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 3);
		end
		if (r < 98) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 40);
	endfunction

	function automatic data_t rand_data();
		case ($urandom_range(0, 13))
			0: return D_MAX;
			1: return D_MIN;
			2: return data_t'(0);
			3: return data_t'(-1);
			4: return data_t'(1);
			5: return ONE_Q;
			6: return data_t'(-16384);
			default: return data_t'($urandom);
		endcase
	endfunction

	function automatic in_word_t word_of(input cmd_t c, input int r, input int xr, input int xi,
		input int yr, input int yi, input int ar, input int ai, input bit l);
		in_word_t w;
		w.cmd     = c;
		w.row     = ROW_W'(r);
		w.x_re    = data_t'(xr);
		w.x_im    = data_t'(xi);
		w.y_re    = data_t'(yr);
		w.y_im    = data_t'(yi);
		w.a_re    = data_t'(ar);
		w.a_im    = data_t'(ai);
		w.last_in = l;
		return w;
	endfunction

	function automatic out_word_t elem_of(input int nr, input int ni, input int r, input bit l);
		out_word_t o;
		o.new_re   = data_t'(nr);
		o.new_im   = data_t'(ni);
		o.out_row  = ROW_W'(r);
		o.last_out = l;
		return o;
	endfunction

	function automatic in_word_t random_word();
		in_word_t w;
		w.x_re = rand_data();
		w.x_im = rand_data();
		w.y_re = rand_data();
		w.y_im = rand_data();
		w.a_re = rand_data();
		w.a_im = rand_data();
		w.last_in = ($urandom_range(0, 7) == 0);
		if (loaded_rows.size() == 0 || $urandom_range(0, 3) == 0) begin
			w.cmd = CMD_LOAD;
			w.row = ROW_W'($urandom_range(0, ROWS - 1));
		end else begin
			w.cmd = CMD_UPDATE;
			w.row = loaded_rows[$urandom_range(0, loaded_rows.size() - 1)];
			if ($urandom_range(0, 15) == 0) begin
				w.y_re = '0;
				w.y_im = '0;
			end
		end
		return w;
	endfunction

	function automatic cfg_t phase_settings(input int ph);
		cfg_t c;
		case (ph)
			0: c = '{data_t'(0), data_t'(0), 1'b0, 1'b0, 1'b0};
			1: c = '{data_t'(0), data_t'(0), 1'b1, 1'b1, 1'b1};
			2: c = '{D_MIN, D_MAX, 1'b0, 1'b1, 1'b1};
			3: c = '{D_MAX, D_MIN, 1'b1, 1'b0, 1'b0};
			default: begin
				c.alpha_re   = rand_data();
				c.alpha_im   = rand_data();
				c.conj_x     = 1'($urandom_range(0, 1));
				c.conj_y     = 1'($urandom_range(0, 1));
				c.accumulate = 1'($urandom_range(0, 1));
			end
		endcase
		return c;
	endfunction

	task automatic send_word(input in_word_t w, input bit pinned, input out_word_t pinned_res);
		int gap;
		gap = burst_mode ? 0 : pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item       <= w;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		// word taken at this edge; the store is written at acceptance
		if (w.cmd == CMD_LOAD) begin
			x_mem_re[w.row] = w.x_re;
			x_mem_im[w.row] = w.x_im;
			if (!row_loaded[w.row]) begin
				row_loaded[w.row] = 1'b1;
				loaded_rows.push_back(w.row);
			end
		end else begin
			pending_elems.push_back(pinned ? pinned_res : update_element(w));
		end
	endtask

	task automatic drain_block();
		item_valid <= 1'b0;
		while (pending_elems.size() != 0) @(posedge clk);
		// loads leave no result, so give the pipeline time to empty
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_ALPHA_RE:   model_cfg.alpha_re   = val;
			REG_ALPHA_IM:   model_cfg.alpha_im   = val;
			REG_CONJ_X:     model_cfg.conj_x     = val[0];
			REG_CONJ_Y:     model_cfg.conj_y     = val[0];
			REG_ACCUMULATE: model_cfg.accumulate = val[0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(input cfg_t c);
		logic [DATA_W-1:0] junk;
		write_reg(REG_ALPHA_RE, c.alpha_re);
		write_reg(REG_ALPHA_IM, c.alpha_im);
		// upper bits of the flag registers carry noise
		junk = DATA_W'($urandom);
		junk[0] = c.conj_x;
		write_reg(REG_CONJ_X, junk);
		junk = DATA_W'($urandom);
		junk[0] = c.conj_y;
		write_reg(REG_CONJ_Y, junk);
		junk = DATA_W'($urandom);
		junk[0] = c.accumulate;
		write_reg(REG_ACCUMULATE, junk);
		if ($urandom_range(0, 1)) begin
			write_reg(CFG_IDX_W'(REG_COUNT + $urandom_range(0, 2)), DATA_W'($urandom));
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic walk_directed(input bit pin_ok);
		foreach (directed_tab[i]) begin
			send_word(directed_tab[i].w, pin_ok && directed_tab[i].pinned, directed_tab[i].res);
		end
	endtask

	// result side: random stall pattern, plus one long hold-off on request
	initial begin
		int run;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (rx_hold_req && !hold_done) begin
				result_stall <= 1'b1;
				hold_active = 1'b1;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
				result_stall <= 1'b0;
				@(posedge clk);
			end else begin
				run = pick_gap();
				if (run > 0) begin
					result_stall <= 1'b1;
					repeat (run) @(posedge clk);
				end
				result_stall <= 1'b0;
				run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 100) : $urandom_range(1, 8);
				repeat (run) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		out_word_t e;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_elems.size() == 0) begin
				$error("result word with nothing expected: row %0d", result.out_row);
				fail_count++;
			end else begin
				e = pending_elems.pop_front();
				if (result.new_re !== e.new_re) begin
					$error("new_re: expected %0d, got %0d", e.new_re, result.new_re);
					fail_count++;
				end
				if (result.new_im !== e.new_im) begin
					$error("new_im: expected %0d, got %0d", e.new_im, result.new_im);
					fail_count++;
				end
				if (result.out_row !== e.out_row) begin
					$error("out_row: expected %0d, got %0d", e.out_row, result.out_row);
					fail_count++;
				end
				if (result.last_out !== e.last_out) begin
					$error("last_out: expected %0d, got %0d", e.last_out, result.last_out);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
			(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		in_word_t w;
		model_cfg = '{ALPHA_RE_RESET, ALPHA_IM_RESET, 1'b0, 1'b0, 1'b1};
		foreach (row_loaded[i]) begin
			row_loaded[i] = 1'b0;
		end

		// pinned results hold only under the reset settings
		directed_tab.push_back('{word_of(CMD_LOAD, 0, 16384, 0, -1, 7, 32767, -32768, 0),
			1'b0, elem_of(0, 0, 0, 0)});
		directed_tab.push_back('{word_of(CMD_UPDATE, 0, 32767, -32768, 16384, 0, 0, 0, 0),
			1'b1, elem_of(16384, 0, 0, 0)});
		// zero y keeps a
		directed_tab.push_back('{word_of(CMD_UPDATE, 0, 0, 0, 0, 0, 32767, -32768, 1),
			1'b1, elem_of(32767, -32768, 0, 1)});
		// accumulate saturates high
		directed_tab.push_back('{word_of(CMD_UPDATE, 0, 0, 0, 16384, 0, 32767, -32768, 0),
			1'b1, elem_of(32767, -32768, 0, 0)});
		directed_tab.push_back('{word_of(CMD_LOAD, 63, -32768, -32768, 32767, 32767, 0, 0, 1),
			1'b0, elem_of(0, 0, 0, 0)});
		directed_tab.push_back('{word_of(CMD_UPDATE, 63, 0, 0, -32768, -32768, -32768, -32768, 0),
			1'b0, elem_of(0, 0, 0, 0)});
		directed_tab.push_back('{word_of(CMD_LOAD, 1, 32767, 32767, 0, 0, 0, 0, 0),
			1'b0, elem_of(0, 0, 0, 0)});
		directed_tab.push_back('{word_of(CMD_UPDATE, 1, 5, 5, 32767, -32768, 32767, 32767, 0),
			1'b0, elem_of(0, 0, 0, 0)});
		directed_tab.push_back('{word_of(CMD_UPDATE, 1, 0, 0, -32768, 32767, -32768, 0, 1),
			1'b0, elem_of(0, 0, 0, 0)});
		// reloading a row with zero
		directed_tab.push_back('{word_of(CMD_LOAD, 0, 0, 0, 1234, -1234, 99, 99, 0),
			1'b0, elem_of(0, 0, 0, 0)});
		directed_tab.push_back('{word_of(CMD_UPDATE, 0, 777, -777, 12345, -321, 100, -100, 0),
			1'b1, elem_of(100, -100, 0, 0)});
		directed_tab.push_back('{word_of(CMD_LOAD, 32, -1, 1, 0, 0, 0, 0, 0),
			1'b0, elem_of(0, 0, 0, 0)});
		directed_tab.push_back('{word_of(CMD_UPDATE, 32, 0, 0, 1, -1, 0, 0, 0),
			1'b0, elem_of(0, 0, 0, 0)});
		directed_tab.push_back('{word_of(CMD_UPDATE, 63, 0, 0, -32768, 0, 0, -32768, 1),
			1'b0, elem_of(0, 0, 0, 0)});
		directed_tab.push_back('{word_of(CMD_LOAD, 5, 8192, -8192, -5, 5, -5, 5, 1),
			1'b0, elem_of(0, 0, 0, 0)});
		directed_tab.push_back('{word_of(CMD_UPDATE, 5, -32768, 32767, 16384, 16384, -1, -1, 0),
			1'b0, elem_of(0, 0, 0, 0)});

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		walk_directed(1'b1);
		drain_block();
		apply_settings('{D_MIN, D_MIN, 1'b1, 1'b1, 1'b0});
		walk_directed(1'b0);
		drain_block();
		apply_settings('{D_MAX, D_MAX, 1'b1, 1'b0, 1'b1});
		walk_directed(1'b0);

		for (int ph = 0; ph < PHASES; ph++) begin
			drain_block();
			apply_settings(phase_settings(ph));
			burst_mode = (ph == PRESSURE_PHASE) || (ph == 1);
			if (ph == PRESSURE_PHASE) begin
				// keep offering words while the result side holds off
				rx_hold_req <= 1'b1;
				while (!hold_active) @(posedge clk);
			end
			for (int n = 0; n < PHASE_WORDS; n++) begin
				w = random_word();
				send_word(w, 1'b0, elem_of(0, 0, 0, 0));
			end
			burst_mode = 1'b0;
		end

		drain_block();
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
